@@ src/mmstk_pkg.sv @@
package mmstk_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int VALUE_BITS    = 32;
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int FIELD_W       = 32;
  localparam int DEPTH_FIELD_W = 9;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // one stack entry: the value and the running min and max up to and including it
  typedef struct packed {
    value_t val;
    value_t run_min;
    value_t run_max;
  } entry_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic slot_free;
  } dp_status_t;

  // low bits of the input field; zero-extended when values are wider than the field
  function automatic value_t from_field(logic [FIELD_W-1:0] f);
    logic [63:0] z;
    z = {32'b0, f};
    return z[VALUE_BITS-1:0];
  endfunction

  // sign-extend or truncate a stored value to the result field width
  function automatic logic [FIELD_W-1:0] to_field(value_t v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[FIELD_W-1:0];
  endfunction

  function automatic logic [DEPTH_FIELD_W-1:0] depth_field(logic [CNT_W-1:0] c);
    logic [31:0] z;
    z = 32'(c);
    return z[DEPTH_FIELD_W-1:0];
  endfunction

endpackage

@@ src/mmstk_if.sv @@
interface mmstk_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface mmstk_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] popped_value;
  logic [8:0]  depth_now;
  logic [31:0] current_min;
  logic [31:0] current_max;
  logic        is_empty;
  logic [1:0]  status;

  modport source (output valid, output popped_value, output depth_now, output current_min,
                  output current_max, output is_empty, output status, input ready);
  modport sink   (input valid, input popped_value, input depth_now, input current_min,
                  input current_max, input is_empty, input status, output ready);
endinterface

@@ src/mmstk_ram.sv @@
module mmstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mmstk_ctrl.sv @@
module mmstk_ctrl import mmstk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (status_i.in_valid) state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = status_i.in_valid;
      end
      S_FIN: begin
        cmd_o.commit = status_i.slot_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ src/mmstk_datapath.sv @@
module mmstk_datapath import mmstk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  mmstk_req_if.sink   req_i,
  mmstk_res_if.source res_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  value_t           top_val_q, top_val_d;
  value_t           min_q, min_d;
  value_t           max_q, max_d;
  req_e             op_q;
  value_t           val_q;

  logic                        ram_we;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  entry_t                      ram_wdata;
  entry_t                      ram_rdata;
  logic [$bits(entry_t)-1:0]   ram_rdata_raw;

  logic             out_valid_q;
  logic [31:0]      res_pop_q, res_pop_d;
  logic [8:0]       res_depth_q, res_depth_d;
  logic [31:0]      res_min_q, res_min_d;
  logic [31:0]      res_max_q, res_max_d;
  logic             res_empty_q, res_empty_d;
  status_e          res_status_q, res_status_d;

  logic             is_full;
  logic             is_empty;
  logic             has_two;
  logic [CNT_W-1:0] cnt_m2;
  value_t           new_min;
  value_t           new_max;

  assign is_full  = (cnt_q == CNT_W'(STACK_DEPTH));
  assign is_empty = (cnt_q == '0);
  assign has_two  = (cnt_q >= CNT_W'(2));
  assign cnt_m2   = cnt_q - CNT_W'(2);

  assign new_min = (is_empty || (val_q < min_q)) ? val_q : min_q;
  assign new_max = (is_empty || (max_q < val_q)) ? val_q : max_q;

  // on a pop the entry below the top is fetched so it can become the cached top
  assign ram_re    = cmd_i.capture && (req_e'(req_i.req_type) == REQ_POP) && has_two;
  assign ram_raddr = cnt_m2[ADDR_W-1:0];
  assign ram_rdata = entry_t'(ram_rdata_raw);

  mmstk_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  always_comb begin
    cnt_d        = cnt_q;
    top_val_d    = top_val_q;
    min_d        = min_q;
    max_d        = max_q;
    ram_we       = 1'b0;
    ram_wdata    = '{val: val_q, run_min: new_min, run_max: new_max};
    res_pop_d    = '0;
    res_status_d = ST_OK;
    unique case (op_q)
      REQ_PUSH: begin
        if (is_full) begin
          res_status_d = ST_OVERFLOW;
        end else begin
          ram_we    = cmd_i.commit;
          cnt_d     = cnt_q + CNT_W'(1);
          top_val_d = val_q;
          min_d     = new_min;
          max_d     = new_max;
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          res_status_d = ST_UNDERFLOW;
        end else begin
          res_pop_d = to_field(top_val_q);
          cnt_d     = cnt_q - CNT_W'(1);
          if (has_two) begin
            top_val_d = ram_rdata.val;
            min_d     = ram_rdata.run_min;
            max_d     = ram_rdata.run_max;
          end
        end
      end
      default: res_status_d = ST_OK;
    endcase
    res_empty_d = (cnt_d == '0);
    res_depth_d = depth_field(cnt_d);
    res_min_d   = res_empty_d ? '0 : to_field(min_d);
    res_max_d   = res_empty_d ? '0 : to_field(max_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_e'(req_i.req_type);
      val_q <= from_field(req_i.push_value);
    end
    if (cmd_i.commit) begin
      top_val_q    <= top_val_d;
      min_q        <= min_d;
      max_q        <= max_d;
      res_pop_q    <= res_pop_d;
      res_depth_q  <= res_depth_d;
      res_min_q    <= res_min_d;
      res_max_q    <= res_max_d;
      res_empty_q  <= res_empty_d;
      res_status_q <= res_status_d;
    end
  end

  assign status_o.in_valid  = req_i.valid;
  assign status_o.slot_free = !out_valid_q || res_o.ready;

  assign req_i.ready        = cmd_i.in_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.popped_value = res_pop_q;
  assign res_o.depth_now    = res_depth_q;
  assign res_o.current_min  = res_min_q;
  assign res_o.current_max  = res_max_q;
  assign res_o.is_empty     = res_empty_q;
  assign res_o.status       = res_status_q;

endmodule

@@ src/min_max_stack_core.sv @@
// min/max stack: a last-in first-out stack of signed values that reports the
// current minimum and maximum with every result. each request item is a push
// or a pop and yields exactly one result item carrying the popped value (zero
// unless a pop succeeded), the depth after the request, the minimum and
// maximum (both zero when empty), an empty flag and a status code. a pop on an
// empty stack or a push on a full one is refused, leaves the stack unchanged
// and reports underflow or overflow. an item has an accept cycle, in which a
// pop starts the registered read of the entry below the top, and then a
// commit cycle that updates the stack and loads the result register.
// every entry stores its value with the running minimum and maximum up to it,
// and the top entry is cached in registers, so that read is the only memory
// access on the path of a pop. the next item is accepted while a result still
// waits in the output register; the commit stalls only while that register
// is full and not being drained. no clearing pass is needed after reset.
module min_max_stack_core import mmstk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmstk_req_if.sink   req_i,
  mmstk_res_if.source res_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer: accept, then commit once the result register has room
  mmstk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  // counter, cached top entry, entry memory and result register
  mmstk_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (dp_status),
    .req_i    (req_i),
    .res_o    (res_o)
  );

endmodule

@@ src/mmstk_checker.sv @@
module mmstk_checker import mmstk_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] popped_value_i,
  input logic [8:0]  depth_now_i,
  input logic [31:0] current_min_i,
  input logic [31:0] current_max_i,
  input logic        is_empty_i,
  input logic [1:0]  status_i
);

  // a waiting result keeps its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(depth_now_i) && $stable(status_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> is_empty_i == (depth_now_i == '0))
    else $error("empty flag disagrees with depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_empty_i |-> current_min_i == '0 && current_max_i == '0)
    else $error("min or max not zero on empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !is_empty_i |-> $signed(current_min_i) <= $signed(current_max_i))
    else $error("minimum above maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == ST_UNDERFLOW || status_i == ST_OVERFLOW)
      |-> popped_value_i == '0 && (status_i == ST_OVERFLOW || is_empty_i))
    else $error("refused request reported inconsistently");

endmodule

bind min_max_stack_core mmstk_checker u_mmstk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .popped_value_i (res_o.popped_value),
  .depth_now_i    (res_o.depth_now),
  .current_min_i  (res_o.current_min),
  .current_max_i  (res_o.current_max),
  .is_empty_i     (res_o.is_empty),
  .status_i       (res_o.status)
);

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmstk_pkg::*;

  // cycles with no item moving on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1600;
  localparam int PHASE_LEN  = RAND_ITEMS / 4;
  localparam int TAIL_CYCLES = 20;

  // one result item as the block should present it
  typedef struct packed {
    logic [31:0] popped;
    logic [8:0]  depth;
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic        empty;
    status_e     status;
  } stack_res_t;

  // directed stimulus row; want is only used when known is set
  typedef struct {
    req_e        op;
    logic [31:0] val;
    bit          known;
    stack_res_t  want;
  } dir_row_t;

  // how the random part steers the depth
  typedef enum {
    WALK_GROW,
    WALK_SHRINK,
    WALK_CHURN
  } walk_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  mmstk_req_if req_ch ();
  mmstk_res_if res_ch ();

  min_max_stack_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  // shadow stack: values plus index stacks of successive minima and maxima
  value_t           shadow_vals [STACK_DEPTH];
  logic [ADDR_W-1:0] low_marks  [STACK_DEPTH];
  logic [ADDR_W-1:0] high_marks [STACK_DEPTH];
  logic [CNT_W-1:0] n_items;
  logic [CNT_W-1:0] n_low;
  logic [CNT_W-1:0] n_high;

  stack_res_t pending_res [$];
  dir_row_t   dir_rows [$];
  stack_res_t want;

  int n_errors    = 0;
  int n_checked   = 0;
  int idle_cycles = 0;

  // idling knobs, percent per cycle, plus calm stretches with no idling at all
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int src_calm      = 0;
  int snk_calm      = 0;

  always #4 clk_i = ~clk_i;

  // next state of the shadow stack and the result that one request produces
  function automatic stack_res_t step_stack(req_e op, logic [31:0] v);
    stack_res_t        r;
    value_t            nv;
    logic [CNT_W-1:0]  top;
    logic              lower;
    logic              higher;
    r        = '0;
    r.status = ST_OK;
    if (op == REQ_PUSH) begin
      if (n_items >= STACK_DEPTH) begin
        // full: refused, nothing changes
        r.status = ST_OVERFLOW;
      end else begin
        nv     = value_t'(v);
        // only a strictly smaller or larger value adds a mark, ties keep the older one
        lower  = (n_low == 0) || (nv < shadow_vals[low_marks[n_low - 1'b1]]);
        higher = (n_high == 0) || (nv > shadow_vals[high_marks[n_high - 1'b1]]);
        shadow_vals[n_items] = nv;
        if (lower) begin
          low_marks[n_low] = n_items[ADDR_W-1:0];
          n_low = n_low + 1'b1;
        end
        if (higher) begin
          high_marks[n_high] = n_items[ADDR_W-1:0];
          n_high = n_high + 1'b1;
        end
        n_items = n_items + 1'b1;
      end
    end else begin
      if (n_items == 0) begin
        // empty: refused, popped value stays zero
        r.status = ST_UNDERFLOW;
      end else begin
        top = n_items - 1'b1;
        // drop marks that point at the leaving entry
        if (n_low > 0 && low_marks[n_low - 1'b1] == top[ADDR_W-1:0]) n_low = n_low - 1'b1;
        if (n_high > 0 && high_marks[n_high - 1'b1] == top[ADDR_W-1:0]) n_high = n_high - 1'b1;
        r.popped = shadow_vals[top];
        n_items  = top;
      end
    end
    r.depth = n_items;
    r.empty = (n_items == 0);
    // min and max read as zero on an empty stack
    if (!r.empty) begin
      r.min_v = shadow_vals[low_marks[n_low - 1'b1]];
      r.max_v = shadow_vals[high_marks[n_high - 1'b1]];
    end
    return r;
  endfunction

  function automatic void add_row(req_e op, logic [31:0] v);
    dir_row_t d;
    d.op    = op;
    d.val   = v;
    d.known = 1'b0;
    d.want  = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void add_known_row(req_e op, logic [31:0] v, logic [31:0] popped,
                                        logic [8:0] depth, logic [31:0] mn, logic [31:0] mx,
                                        logic empty, status_e st);
    dir_row_t d;
    d.op          = op;
    d.val         = v;
    d.known       = 1'b1;
    d.want.popped = popped;
    d.want.depth  = depth;
    d.want.min_v  = mn;
    d.want.max_v  = mx;
    d.want.empty  = empty;
    d.want.status = st;
    dir_rows.push_back(d);
  endfunction

  // value mix: full range, small values that tie often, and values near the extremes
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      4, 5:    v = 32'($urandom_range(8)) - 32'd4;
      6: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      7:       v = 32'h8000_0000 + 32'($urandom_range(3));
      8:       v = 32'h7fff_ffff - 32'($urandom_range(3));
      9: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(req_e op, logic [31:0] v, bit known, stack_res_t typed_res);
    stack_res_t pred;
    if (src_calm > 0) src_calm--;
    else if ($urandom_range(39) == 0) src_calm = $urandom_range(30, 10);
    while (src_calm == 0 && $urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= op;
    req_ch.push_value <= v;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    // item taken at this edge
    pred = step_stack(op, v);
    if (known) pending_res.push_back(typed_res);
    else pending_res.push_back(pred);
    @(negedge clk_i);
  endtask

  // result side back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    if (snk_calm > 0) snk_calm <= snk_calm - 1;
    else if ($urandom_range(39) == 0) snk_calm <= $urandom_range(30, 10);
    res_ch.ready <= (snk_calm > 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  // result check against the oldest expectation, plus the stall watchdog
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready) begin
      if (pending_res.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_checked));
      end else begin
        want = pending_res.pop_front();
        if (res_ch.popped_value !== want.popped)
          report_mismatch($sformatf("result %0d popped_value %h, expected %h",
                                    n_checked, res_ch.popped_value, want.popped));
        if (res_ch.depth_now !== want.depth)
          report_mismatch($sformatf("result %0d depth_now %0d, expected %0d",
                                    n_checked, res_ch.depth_now, want.depth));
        if (res_ch.current_min !== want.min_v)
          report_mismatch($sformatf("result %0d current_min %h, expected %h",
                                    n_checked, res_ch.current_min, want.min_v));
        if (res_ch.current_max !== want.max_v)
          report_mismatch($sformatf("result %0d current_max %h, expected %h",
                                    n_checked, res_ch.current_max, want.max_v));
        if (res_ch.is_empty !== want.empty)
          report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                    n_checked, res_ch.is_empty, want.empty));
        if (res_ch.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    n_checked, res_ch.status, want.status));
      end
      n_checked++;
    end
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_res.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    walk_e       walk;
    int          push_pct;
    int          rim_hits;
    int          churn_left;
    req_e        op;
    stack_res_t  no_res;

    // known values on every input from time zero
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PUSH;
    req_ch.push_value = '0;
    res_ch.ready      = 1'b0;
    n_items           = '0;
    n_low             = '0;
    n_high            = '0;
    no_res            = '0;

    // directed part: refusals, extremes, ties on min and max, unwinding to empty
    add_known_row(REQ_POP,  32'h0000_0000, 32'h0, 9'd0, 32'h0, 32'h0, 1'b1, ST_UNDERFLOW);
    add_known_row(REQ_PUSH, 32'h8000_0000, 32'h0, 9'd1, 32'h8000_0000, 32'h8000_0000,
                  1'b0, ST_OK);
    add_known_row(REQ_PUSH, 32'h7fff_ffff, 32'h0, 9'd2, 32'h8000_0000, 32'h7fff_ffff,
                  1'b0, ST_OK);
    add_known_row(REQ_POP,  32'hffff_ffff, 32'h7fff_ffff, 9'd1, 32'h8000_0000, 32'h8000_0000,
                  1'b0, ST_OK);
    add_known_row(REQ_POP,  32'h1234_5678, 32'h8000_0000, 9'd0, 32'h0, 32'h0, 1'b1, ST_OK);
    add_known_row(REQ_POP,  32'hffff_ffff, 32'h0, 9'd0, 32'h0, 32'h0, 1'b1, ST_UNDERFLOW);
    add_known_row(REQ_PUSH, 32'h0000_0000, 32'h0, 9'd1, 32'h0, 32'h0, 1'b0, ST_OK);
    add_row(REQ_PUSH, 32'h0000_0000);   // tie on both min and max
    add_row(REQ_PUSH, 32'hffff_ffff);   // new min
    add_row(REQ_PUSH, 32'hffff_ffff);   // tie on min
    add_row(REQ_PUSH, 32'h0000_0001);   // new max
    add_row(REQ_PUSH, 32'h0000_0001);   // tie on max
    add_row(REQ_POP,  32'h0);           // max mark stays on the earlier entry
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);           // back to empty
    add_row(REQ_PUSH, 32'h5a5a_5a5a);
    add_row(REQ_PUSH, 32'ha5a5_a5a5);
    add_row(REQ_PUSH, 32'h7fff_fffe);
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);
    add_row(REQ_POP,  32'h0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].known, dir_rows[i].want);

    // random part: climb to full, push into the wall, drain, poke underflow, churn
    walk       = WALK_GROW;
    rim_hits   = 0;
    churn_left = 0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        case (k / PHASE_LEN)
          0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1:       begin src_idle_pct = 55; snk_stall_pct = 0;  end
          2:       begin src_idle_pct = 0;  snk_stall_pct = 55; end
          default: begin src_idle_pct = 36; snk_stall_pct = 36; end
        endcase
      end
      case (walk)
        WALK_GROW: begin
          push_pct = 85;
          if (n_items == STACK_DEPTH) begin
            rim_hits++;
            if (rim_hits > 4) begin
              walk     = WALK_SHRINK;
              rim_hits = 0;
            end
          end
        end
        WALK_SHRINK: begin
          push_pct = 15;
          if (n_items == 0) begin
            rim_hits++;
            if (rim_hits > 4) begin
              walk       = WALK_CHURN;
              rim_hits   = 0;
              churn_left = $urandom_range(150, 60);
            end
          end
        end
        default: begin
          push_pct = 50;
          churn_left--;
          if (churn_left <= 0) walk = WALK_GROW;
        end
      endcase
      op = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
      send_item(op, pick_value(), 1'b0, no_res);
    end
    req_ch.valid <= 1'b0;

    // drain: every expectation met, then a short tail for stray results
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ min_max_stack_core.f @@
src/mmstk_pkg.sv
src/mmstk_if.sv
src/mmstk_ram.sv
src/mmstk_ctrl.sv
src/mmstk_datapath.sv
src/min_max_stack_core.sv
src/mmstk_checker.sv
tb/sv/tb.sv
